// ===== design/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

  localparam int FIELD_W   = 32;
  localparam int RES_NUM_W = 64;
  localparam int RES_DEN_W = 63;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Operand pairing chosen at the front of the pipeline.
  typedef enum logic [1:0] {
    KIND_PROD,
    KIND_SAME,
    KIND_MIXED,
    KIND_ZERO
  } kind_t;

  // Final way of forming the result, known once the divisibility test is done.
  typedef enum logic [2:0] {
    FORM_PROD,
    FORM_SAME,
    FORM_SCALE,
    FORM_CROSS,
    FORM_ZERO
  } form_t;

endpackage
`default_nettype wire

// ===== design/rau_in_if.sv =====
`default_nettype none
interface rau_in_if;
  import rau_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic signed [FIELD_W-1:0]  a_numerator;
  logic signed [FIELD_W-1:0]  a_denominator;
  logic signed [FIELD_W-1:0]  b_numerator;
  logic signed [FIELD_W-1:0]  b_denominator;

  modport source (output valid, req_type, a_numerator, a_denominator, b_numerator,
                  b_denominator, input ready);
  modport sink (input valid, req_type, a_numerator, a_denominator, b_numerator,
                b_denominator, output ready);
endinterface
`default_nettype wire

// ===== design/rau_out_if.sv =====
`default_nettype none
interface rau_out_if;
  import rau_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [RES_NUM_W-1:0]  res_numerator;
  logic signed [RES_DEN_W-1:0]  res_denominator;
  logic                         zero_den_error;

  modport source (output valid, res_numerator, res_denominator, zero_den_error,
                  input ready);
  modport sink (input valid, res_numerator, res_denominator, zero_den_error,
                output ready);
endinterface
`default_nettype wire

// ===== design/rational_arith_unit.sv =====
`default_nettype none
// Rational arithmetic unit: adds, subtracts, multiplies or divides two fractions
// and returns the unreduced result, one transaction per clock at full rate while
// the output accepts. Each transaction passes through sign normalization and
// operand pairing, the bit-per-stage divider that tests whether the larger
// denominator is a multiple of the smaller, a multiplier stage and a summing
// stage into the output register. Only the low VALUE_BITS bits of each operand
// are used, taken as signed. An add or subtract with exactly one zero denominator
// returns 0/0 with zero_den_error set. Backpressure stalls only the stages that
// hold data, so empty stages keep filling while a result waits at the output.
module rational_arith_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rau_in_if.sink     in_chan,
  rau_out_if.source  out_chan
);
  import rau_pkg::*;

  localparam int W = VALUE_BITS;

  logic              p_valid, p_ready;
  kind_t             p_kind;
  logic signed [W:0] p_xn, p_yn;
  logic [W-1:0]      p_xd, p_yd;

  logic              d_valid, d_ready;
  kind_t             d_kind;
  logic signed [W:0] d_xn, d_yn;
  logic [W-1:0]      d_xd, d_yd, d_quo;
  logic              d_rem_zero;

  logic              m_valid, m_ready;
  form_t             m_form;
  logic signed [RES_NUM_W-1:0] m_m1, m_m2;
  logic [RES_NUM_W-1:0] m_m3;
  logic signed [W:0] m_xn, m_yn;
  logic [W-1:0]      m_xd;

  rau_prep #(.W(W)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .req_type  (in_chan.req_type),
    .a_num     (in_chan.a_numerator),
    .a_den     (in_chan.a_denominator),
    .b_num     (in_chan.b_numerator),
    .b_den     (in_chan.b_denominator),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .kind      (p_kind),
    .xn        (p_xn),
    .xd        (p_xd),
    .yn        (p_yn),
    .yd        (p_yd)
  );

  rau_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .kind_in   (p_kind),
    .xn_in     (p_xn),
    .xd_in     (p_xd),
    .yn_in     (p_yn),
    .yd_in     (p_yd),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .kind      (d_kind),
    .xn        (d_xn),
    .xd        (d_xd),
    .yn        (d_yn),
    .yd        (d_yd),
    .quo       (d_quo),
    .rem_zero  (d_rem_zero)
  );

  rau_mul #(.W(W)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .kind      (d_kind),
    .xn_in     (d_xn),
    .xd_in     (d_xd),
    .yn_in     (d_yn),
    .yd_in     (d_yd),
    .quo       (d_quo),
    .rem_zero  (d_rem_zero),
    .out_valid (m_valid),
    .out_ready (m_ready),
    .form      (m_form),
    .m1        (m_m1),
    .m2        (m_m2),
    .m3        (m_m3),
    .xn        (m_xn),
    .yn        (m_yn),
    .xd        (m_xd)
  );

  rau_sum #(.W(W)) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .form      (m_form),
    .m1        (m_m1),
    .m2        (m_m2),
    .m3        (m_m3),
    .xn        (m_xn),
    .yn        (m_yn),
    .xd        (m_xd),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .res_num   (out_chan.res_numerator),
    .res_den   (out_chan.res_denominator),
    .err       (out_chan.zero_den_error)
  );
endmodule
`default_nettype wire

// ===== design/rau_prep.sv =====
`default_nettype none
module rau_prep #(
  parameter int W = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        req_type,
  input  logic signed [rau_pkg::FIELD_W-1:0] a_num,
  input  logic signed [rau_pkg::FIELD_W-1:0] a_den,
  input  logic signed [rau_pkg::FIELD_W-1:0] b_num,
  input  logic signed [rau_pkg::FIELD_W-1:0] b_den,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rau_pkg::kind_t                    kind,
  output logic signed [W:0]                 xn,
  output logic [W-1:0]                      xd,
  output logic signed [W:0]                 yn,
  output logic [W-1:0]                      yd
);
  import rau_pkg::*;

  op_t              op;
  logic [W-1:0]     bn_raw, bd_raw;
  logic signed [W:0] an_e, bn_e, an_n, bn_n;
  logic [W-1:0]     ad_m, bd_m;
  kind_t            kind_nxt;
  logic signed [W:0] xn_nxt, yn_nxt;
  logic [W-1:0]     xd_nxt, yd_nxt;

  logic             v_r;
  kind_t            kind_r;
  logic signed [W:0] xn_r, yn_r;
  logic [W-1:0]     xd_r, yd_r;

  always_comb begin
    op = op_t'(req_type);
    // Divide works on the reciprocal of the second operand.
    if (op == OP_DIV) begin
      bn_raw = b_den[W-1:0];
      bd_raw = b_num[W-1:0];
    end else begin
      bn_raw = b_num[W-1:0];
      bd_raw = b_den[W-1:0];
    end
    an_e = (W+1)'(signed'(a_num[W-1:0]));
    bn_e = (W+1)'(signed'(bn_raw));
    if (op == OP_SUB) begin
      bn_e = -bn_e;
    end
    // Move each operand's sign to its numerator.
    if (a_den[W-1]) begin
      ad_m = (~a_den[W-1:0]) + W'(1);
      an_n = -an_e;
    end else begin
      ad_m = a_den[W-1:0];
      an_n = an_e;
    end
    if (bd_raw[W-1]) begin
      bd_m = (~bd_raw) + W'(1);
      bn_n = -bn_e;
    end else begin
      bd_m = bd_raw;
      bn_n = bn_e;
    end
  end

  always_comb begin
    kind_nxt = KIND_PROD;
    xn_nxt   = an_n;
    xd_nxt   = ad_m;
    yn_nxt   = bn_n;
    yd_nxt   = bd_m;
    if (op == OP_ADD || op == OP_SUB) begin
      if (ad_m == bd_m) begin
        kind_nxt = KIND_SAME;
      end else begin
        // x takes the operand with the larger denominator.
        if (bd_m > ad_m) begin
          xn_nxt = bn_n;
          xd_nxt = bd_m;
          yn_nxt = an_n;
          yd_nxt = ad_m;
        end
        kind_nxt = ((bd_m > ad_m) ? (ad_m == '0) : (bd_m == '0)) ? KIND_ZERO : KIND_MIXED;
      end
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_r <= kind_nxt;
      xn_r   <= xn_nxt;
      xd_r   <= xd_nxt;
      yn_r   <= yn_nxt;
      yd_r   <= yd_nxt;
    end
  end

  assign out_valid = v_r;
  assign kind      = kind_r;
  assign xn        = xn_r;
  assign xd        = xd_r;
  assign yn        = yn_r;
  assign yd        = yd_r;
endmodule
`default_nettype wire

// ===== design/rau_div.sv =====
`default_nettype none
module rau_div #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rau_pkg::kind_t    kind_in,
  input  logic signed [W:0] xn_in,
  input  logic [W-1:0]      xd_in,
  input  logic signed [W:0] yn_in,
  input  logic [W-1:0]      yd_in,
  output logic              out_valid,
  input  logic              out_ready,
  output rau_pkg::kind_t    kind,
  output logic signed [W:0] xn,
  output logic [W-1:0]      xd,
  output logic signed [W:0] yn,
  output logic [W-1:0]      yd,
  output logic [W-1:0]      quo,
  output logic              rem_zero
);
  import rau_pkg::*;

  // One quotient bit per stage, restoring xd / yd from the top bit down.
  logic [W:0]        rdy;
  logic              v_r   [W];
  kind_t             k_r   [W];
  logic signed [W:0] xn_r  [W];
  logic signed [W:0] yn_r  [W];
  logic [W-1:0]      xd_r  [W];
  logic [W-1:0]      yd_r  [W];
  logic [W-1:0]      rem_r [W];
  logic [W-1:0]      q_r   [W];

  logic              src_v   [W];
  kind_t             src_k   [W];
  logic signed [W:0] src_xn  [W];
  logic signed [W:0] src_yn  [W];
  logic [W-1:0]      src_xd  [W];
  logic [W-1:0]      src_yd  [W];
  logic [W-1:0]      src_rem [W];
  logic [W-1:0]      src_q   [W];

  assign rdy[W] = out_ready;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0]   sh;
    logic [W+1:0] diff;
    logic         qbit;

    if (k == 0) begin : g_first
      assign src_v[k]   = in_valid;
      assign src_k[k]   = kind_in;
      assign src_xn[k]  = xn_in;
      assign src_yn[k]  = yn_in;
      assign src_xd[k]  = xd_in;
      assign src_yd[k]  = yd_in;
      assign src_rem[k] = '0;
      assign src_q[k]   = '0;
    end else begin : g_next
      assign src_v[k]   = v_r[k-1];
      assign src_k[k]   = k_r[k-1];
      assign src_xn[k]  = xn_r[k-1];
      assign src_yn[k]  = yn_r[k-1];
      assign src_xd[k]  = xd_r[k-1];
      assign src_yd[k]  = yd_r[k-1];
      assign src_rem[k] = rem_r[k-1];
      assign src_q[k]   = q_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_comb begin
      sh   = {src_rem[k], src_xd[k][W-1-k]};
      diff = {1'b0, sh} - {2'b00, src_yd[k]};
      qbit = ~diff[W+1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v[k]) begin
        k_r[k]   <= src_k[k];
        xn_r[k]  <= src_xn[k];
        yn_r[k]  <= src_yn[k];
        xd_r[k]  <= src_xd[k];
        yd_r[k]  <= src_yd[k];
        rem_r[k] <= qbit ? diff[W-1:0] : sh[W-1:0];
        q_r[k]   <= {src_q[k][W-2:0], qbit};
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[W-1];
  assign kind      = k_r[W-1];
  assign xn        = xn_r[W-1];
  assign yn        = yn_r[W-1];
  assign xd        = xd_r[W-1];
  assign yd        = yd_r[W-1];
  assign quo       = q_r[W-1];
  assign rem_zero  = (rem_r[W-1] == '0);
endmodule
`default_nettype wire

// ===== design/rau_mul.sv =====
`default_nettype none
module rau_mul #(
  parameter int W = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rau_pkg::kind_t                       kind,
  input  logic signed [W:0]                    xn_in,
  input  logic [W-1:0]                         xd_in,
  input  logic signed [W:0]                    yn_in,
  input  logic [W-1:0]                         yd_in,
  input  logic [W-1:0]                         quo,
  input  logic                                 rem_zero,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output rau_pkg::form_t                       form,
  output logic signed [rau_pkg::RES_NUM_W-1:0] m1,
  output logic signed [rau_pkg::RES_NUM_W-1:0] m2,
  output logic [rau_pkg::RES_NUM_W-1:0]        m3,
  output logic signed [W:0]                    xn,
  output logic signed [W:0]                    yn,
  output logic [W-1:0]                         xd
);
  import rau_pkg::*;

  form_t               form_nxt;
  logic signed [W:0]   ma, mb;
  logic signed [2*W+1:0] p1, p2;
  logic [2*W-1:0]      p3;

  logic                v_r;
  form_t               form_r;
  logic signed [RES_NUM_W-1:0] m1_r, m2_r;
  logic [RES_NUM_W-1:0] m3_r;
  logic signed [W:0]   xn_r, yn_r;
  logic [W-1:0]        xd_r;

  always_comb begin
    case (kind)
      KIND_PROD:  form_nxt = FORM_PROD;
      KIND_SAME:  form_nxt = FORM_SAME;
      KIND_MIXED: form_nxt = rem_zero ? FORM_SCALE : FORM_CROSS;
      KIND_ZERO:  form_nxt = FORM_ZERO;
      default:    form_nxt = FORM_ZERO;
    endcase
  end

  // The first product is the numerator product, the scaled small numerator,
  // or the first cross term, depending on the form.
  always_comb begin
    case (form_nxt)
      FORM_PROD: begin
        ma = xn_in;
        mb = yn_in;
      end
      FORM_SCALE: begin
        ma = yn_in;
        mb = signed'({1'b0, quo});
      end
      default: begin
        ma = xn_in;
        mb = signed'({1'b0, yd_in});
      end
    endcase
    p1 = ma * mb;
    p2 = yn_in * signed'({1'b0, xd_in});
    p3 = xd_in * yd_in;
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      form_r <= form_nxt;
      m1_r   <= RES_NUM_W'(p1);
      m2_r   <= RES_NUM_W'(p2);
      m3_r   <= RES_NUM_W'(p3);
      xn_r   <= xn_in;
      yn_r   <= yn_in;
      xd_r   <= xd_in;
    end
  end

  assign out_valid = v_r;
  assign form      = form_r;
  assign m1        = m1_r;
  assign m2        = m2_r;
  assign m3        = m3_r;
  assign xn        = xn_r;
  assign yn        = yn_r;
  assign xd        = xd_r;
endmodule
`default_nettype wire

// ===== design/rau_sum.sv =====
`default_nettype none
module rau_sum #(
  parameter int W = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rau_pkg::form_t                       form,
  input  logic signed [rau_pkg::RES_NUM_W-1:0] m1,
  input  logic signed [rau_pkg::RES_NUM_W-1:0] m2,
  input  logic [rau_pkg::RES_NUM_W-1:0]        m3,
  input  logic signed [W:0]                    xn,
  input  logic signed [W:0]                    yn,
  input  logic [W-1:0]                         xd,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rau_pkg::RES_NUM_W-1:0] res_num,
  output logic signed [rau_pkg::RES_DEN_W-1:0] res_den,
  output logic                                 err
);
  import rau_pkg::*;

  logic signed [RES_NUM_W-1:0] rn_nxt;
  logic [RES_DEN_W-1:0]        rd_nxt;
  logic                        err_nxt;

  logic                        v_r;
  logic signed [RES_NUM_W-1:0] rn_r;
  logic [RES_DEN_W-1:0]        rd_r;
  logic                        err_r;

  always_comb begin
    rn_nxt  = '0;
    rd_nxt  = '0;
    err_nxt = 1'b0;
    case (form)
      FORM_PROD: begin
        rn_nxt = m1;
        rd_nxt = m3[RES_DEN_W-1:0];
      end
      FORM_SAME: begin
        rn_nxt = RES_NUM_W'(xn) + RES_NUM_W'(yn);
        rd_nxt = RES_DEN_W'(xd);
      end
      FORM_SCALE: begin
        rn_nxt = RES_NUM_W'(xn) + m1;
        rd_nxt = RES_DEN_W'(xd);
      end
      FORM_CROSS: begin
        rn_nxt = m1 + m2;
        rd_nxt = m3[RES_DEN_W-1:0];
      end
      FORM_ZERO: begin
        err_nxt = 1'b1;
      end
      default: begin
        err_nxt = 1'b0;
      end
    endcase
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rn_r  <= rn_nxt;
      rd_r  <= rd_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_valid = v_r;
  assign res_num   = rn_r;
  assign res_den   = signed'(rd_r);
  assign err       = err_r;
endmodule
`default_nettype wire

// ===== tb/tb_rational_arith_unit.sv =====
`default_nettype none
module tb_rational_arith_unit;
  import rau_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int LATENCY = VALUE_BITS + 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1500;

  typedef struct packed {
    logic [1:0] op;
    logic signed [31:0] an;
    logic signed [31:0] ad;
    logic signed [31:0] bn;
    logic signed [31:0] bd;
  } operands_t;

  typedef struct packed {
    logic [63:0] num;
    logic [62:0] den;
    logic        err;
  } fraction_t;

  typedef struct packed {
    operands_t  stim;
    logic       has_fixed;
    fraction_t  fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  rau_in_if  in_chan();
  rau_out_if out_chan();

  rational_arith_unit #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  fraction_t expected_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;

  function automatic logic signed [63:0] sext_field(logic [31:0] v);
    logic [63:0] x;
    x = 64'(v) & ((64'd1 << VALUE_BITS) - 64'd1);
    if (x[VALUE_BITS-1]) x = x - (64'd1 << VALUE_BITS);
    return x;
  endfunction

  function automatic fraction_t predict_fraction(operands_t s);
    logic signed [63:0] an, ad, bn, bd, t, gn, gd, sn, sd;
    logic [63:0] rn, rd, q;
    fraction_t r;
    an = sext_field(s.an); ad = sext_field(s.ad);
    bn = sext_field(s.bn); bd = sext_field(s.bd);
    rn = 0; rd = 0; r.err = 0;
    if (s.op == OP_MUL || s.op == OP_DIV) begin
      if (s.op == OP_DIV) begin
        t = bn; bn = bd; bd = t;
      end
      if (ad < 0) begin ad = -ad; an = -an; end
      if (bd < 0) begin bd = -bd; bn = -bn; end
      rn = an * bn;
      rd = ad * bd;
    end else begin
      if (s.op == OP_SUB) bn = -bn;
      if (ad < 0) begin ad = -ad; an = -an; end
      if (bd < 0) begin bd = -bd; bn = -bn; end
      if (ad == bd) begin
        rn = an + bn;
        rd = ad;
      end else begin
        gn = an; gd = ad; sn = bn; sd = bd;
        if (bd > ad) begin
          gn = bn; gd = bd; sn = an; sd = ad;
        end
        if (sd == 0) begin
          r.err = 1;
        end else if ((64'(gd) % 64'(sd)) == 0) begin
          q = 64'(gd) / 64'(sd);
          rn = gn + sn * q;
          rd = gd;
        end else begin
          rn = gn * sd + sn * gd;
          rd = gd * sd;
        end
      end
    end
    r.num = rn;
    r.den = rd[62:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000001;
      2: return 32'(signed'($urandom_range(0, 8)) - 4);
      3: return 0;
      4, 5: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic operands_t rand_operands();
    operands_t s;
    logic signed [31:0] k;
    s.op = 2'($urandom_range(0, 3));
    s.an = rand_field(); s.bn = rand_field();
    s.ad = rand_field(); s.bd = rand_field();
    // Steer many add/subtract transactions onto equal or multiple denominators.
    case ($urandom_range(0, 3))
      0: s.bd = ($urandom_range(0, 1)) ? s.ad : -s.ad;
      1: begin
        k = $urandom_range(1, 50);
        s.ad = 32'(signed'($urandom_range(1, 40000)) - 20000);
        s.bd = s.ad * k;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic stim_row_t mk(logic [1:0] op, int an, int ad, int bn, int bd,
                                   bit fx = 0, logic [63:0] n = 0, logic [62:0] d = 0,
                                   bit e = 0);
    stim_row_t r;
    r.stim = '{op, an, ad, bn, bd};
    r.has_fixed = fx;
    r.fixed = '{n, d, e};
    return r;
  endfunction

  stim_row_t directed[$];

  task automatic add_row(stim_row_t r);
    directed.insert(directed.size(), r);
  endtask

  // The sender drops valid only when the drawn gap is not empty.
  task automatic random_gap(int long_pct);
    int n;
    if ($urandom_range(0, 99) < long_pct) n = $urandom_range(20, 80);
    else if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 3);
    else n = 0;
    if (n > 0) begin
      in_chan.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_operands(operands_t s);
    in_chan.valid         <= 1'b1;
    in_chan.req_type      <= s.op;
    in_chan.a_numerator   <= s.an;
    in_chan.a_denominator <= s.ad;
    in_chan.b_numerator   <= s.bn;
    in_chan.b_denominator <= s.bd;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  initial begin
    in_chan.valid = 0; in_chan.req_type = 0;
    in_chan.a_numerator = 0; in_chan.a_denominator = 0;
    in_chan.b_numerator = 0; in_chan.b_denominator = 0;
    out_chan.ready = 0;
    add_row(mk(OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0));
    add_row(mk(OP_ADD, 1, 2, 1, 2, 1, 2, 2, 0));
    add_row(mk(OP_ADD, 1, 2, 1, 4, 1, 3, 4, 0));
    add_row(mk(OP_SUB, 1, 2, 1, 3, 1, 1, 6, 0));
    add_row(mk(OP_MUL, 2, 3, 5, 7, 1, 10, 21, 0));
    add_row(mk(OP_DIV, 2, 3, 5, 7, 1, 14, 15, 0));
    add_row(mk(OP_ADD, 1, -2, 1, 3, 1, -1, 6, 0));
    add_row(mk(OP_ADD, 1, 0, 1, 3, 1, 0, 0, 1));
    add_row(mk(OP_SUB, 5, 7, 1, 0, 1, 0, 0, 1));
    add_row(mk(OP_ADD, 3, 0, 4, 0, 1, 7, 0, 0));
    add_row(mk(OP_MUL, 3, 0, 4, 5, 1, 12, 0, 0));
    add_row(mk(OP_DIV, 3, 5, 0, 7, 1, 21, 0, 0));
    add_row(mk(OP_DIV, 3, 5, -2, 7));
    add_row(mk(OP_MUL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
    add_row(mk(OP_MUL, 32'sh80000001, 32'sh7FFFFFFF, 32'sh80000001, 32'sh80000001));
    add_row(mk(OP_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFE));
    add_row(mk(OP_SUB, 32'sh80000001, 32'sh80000001, 32'sh7FFFFFFF, 3));
    add_row(mk(OP_ADD, 32'sh80000000, 32'sh80000000, 1, 1));
    add_row(mk(OP_DIV, 32'sh80000000, 1, 32'sh80000000, 32'sh80000000));
    add_row(mk(OP_ADD, 0, 1, 0, -1, 1, 0, 1, 0));
    add_row(mk(OP_SUB, -1, -1, -1, -1, 1, 0, 1, 0));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].has_fixed && directed[i].fixed != predict_fraction(directed[i].stim)) begin
        $display("%0t table row %0d: expected %h actual predictor %h", $time, i,
                 directed[i].fixed, predict_fraction(directed[i].stim));
        errors++;
      end
      send_operands(directed[i].stim);
      expected_q.insert(expected_q.size(),
                        directed[i].has_fixed ? directed[i].fixed
                                              : predict_fraction(directed[i].stim));
      if ($urandom_range(0, 1)) begin
        random_gap(5);
      end
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      operands_t s;
      s = rand_operands();
      send_operands(s);
      expected_q.insert(expected_q.size(), predict_fraction(s));
      if (i == N_RANDOM / 2) begin
        in_chan.valid <= 1'b0;
        wait (expected_q.size() == 0);
        @(posedge clk);
      end else if (i % 200 < 150 && $urandom_range(0, 2) == 0) begin
        random_gap(4);
      end
    end
    in_chan.valid <= 1'b0;
    stim_done = 1;
  end

  // Result side: random stalls, with a long stretch of full-rate acceptance.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (($time / 20000) % 3 == 1) out_chan.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 2) out_chan.ready <= 1'b0;
      else out_chan.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    fraction_t got, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.res_numerator, out_chan.res_denominator, out_chan.zero_den_error};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transaction: actual %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.num !== want.num) begin
          $display("%0t res_numerator: expected %h actual %h", $time, want.num, got.num);
          errors++;
        end
        if (got.den !== want.den) begin
          $display("%0t res_denominator: expected %h actual %h", $time, want.den, got.den);
          errors++;
        end
        if (got.err !== want.err) begin
          $display("%0t zero_den_error: expected %b actual %b", $time, want.err, got.err);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stim_done && expected_q.size() == 0);
    repeat (4 * LATENCY) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("** rational_arith_unit: PASSED **");
    else
      $display("** rational_arith_unit: FAILED **");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("** rational_arith_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
